// ----- hdl/snd_pkg.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// snd_pkg: shared definitions for the 2D simplex noise pipeline
// Constants, register indexes, the configuration struct and the
// permutation table used by the hashing stages.
// ----------------------------------------------------------------------------
package snd_pkg;

  localparam int FRAC_BITS_DEF = 16;
  localparam int PERM_ENTRIES  = 256;
  localparam int CONST_FB      = 22;
  localparam int SKEW_C        = 1535222;
  localparam int UNSKEW_C      = 886361;
  localparam int GAIN_C        = 189711096;
  localparam int COORD_W       = 40;
  localparam int SCALE_W       = 24;
  localparam int OUT_W         = 16;
  localparam int NUM_STAGES    = 16;
  localparam logic [SCALE_W-1:0] SCALE_RST = 24'd65536;

  typedef enum logic [1:0] {
    REG_SCALE = 2'd0,
    REG_OFFX  = 2'd1,
    REG_OFFY  = 2'd2
  } reg_idx_e;

  typedef struct packed {
    logic [SCALE_W-1:0] scale;
    logic [COORD_W-1:0] off_x;
    logic [COORD_W-1:0] off_y;
  } snd_cfg_t;

  localparam logic [7:0] PERM_ROM [PERM_ENTRIES] = '{
    8'd151, 8'd160, 8'd137, 8'd91, 8'd90, 8'd15, 8'd131, 8'd13, 8'd201, 8'd95,
    8'd96, 8'd53, 8'd194, 8'd233, 8'd7, 8'd225, 8'd140, 8'd36, 8'd103, 8'd30,
    8'd69, 8'd142, 8'd8, 8'd99, 8'd37, 8'd240, 8'd21, 8'd10, 8'd23, 8'd190,
    8'd6, 8'd148, 8'd247, 8'd120, 8'd234, 8'd75, 8'd0, 8'd26, 8'd197, 8'd62,
    8'd94, 8'd252, 8'd219, 8'd203, 8'd117, 8'd35, 8'd11, 8'd32, 8'd57, 8'd177,
    8'd33, 8'd88, 8'd237, 8'd149, 8'd56, 8'd87, 8'd174, 8'd20, 8'd125, 8'd136,
    8'd171, 8'd168, 8'd68, 8'd175, 8'd74, 8'd165, 8'd71, 8'd134, 8'd139, 8'd48,
    8'd27, 8'd166, 8'd77, 8'd146, 8'd158, 8'd231, 8'd83, 8'd111, 8'd229, 8'd122,
    8'd60, 8'd211, 8'd133, 8'd230, 8'd220, 8'd105, 8'd92, 8'd41, 8'd55, 8'd46,
    8'd245, 8'd40, 8'd244, 8'd102, 8'd143, 8'd54, 8'd65, 8'd25, 8'd63, 8'd161,
    8'd1, 8'd216, 8'd80, 8'd73, 8'd209, 8'd76, 8'd132, 8'd187, 8'd208, 8'd89,
    8'd18, 8'd169, 8'd200, 8'd196, 8'd135, 8'd130, 8'd116, 8'd188, 8'd159, 8'd86,
    8'd164, 8'd100, 8'd109, 8'd198, 8'd173, 8'd186, 8'd3, 8'd64, 8'd52, 8'd217,
    8'd226, 8'd250, 8'd124, 8'd123, 8'd5, 8'd202, 8'd38, 8'd147, 8'd118, 8'd126,
    8'd255, 8'd82, 8'd85, 8'd212, 8'd207, 8'd206, 8'd59, 8'd227, 8'd47, 8'd16,
    8'd58, 8'd17, 8'd182, 8'd189, 8'd28, 8'd42, 8'd223, 8'd183, 8'd170, 8'd213,
    8'd119, 8'd248, 8'd152, 8'd2, 8'd44, 8'd154, 8'd163, 8'd70, 8'd221, 8'd153,
    8'd101, 8'd155, 8'd167, 8'd43, 8'd172, 8'd9, 8'd129, 8'd22, 8'd39, 8'd253,
    8'd19, 8'd98, 8'd108, 8'd110, 8'd79, 8'd113, 8'd224, 8'd232, 8'd178, 8'd185,
    8'd112, 8'd104, 8'd218, 8'd246, 8'd97, 8'd228, 8'd251, 8'd34, 8'd242, 8'd193,
    8'd238, 8'd210, 8'd144, 8'd12, 8'd191, 8'd179, 8'd162, 8'd241, 8'd81, 8'd51,
    8'd145, 8'd235, 8'd249, 8'd14, 8'd239, 8'd107, 8'd49, 8'd192, 8'd214, 8'd31,
    8'd181, 8'd199, 8'd106, 8'd157, 8'd184, 8'd84, 8'd204, 8'd176, 8'd115, 8'd121,
    8'd50, 8'd45, 8'd127, 8'd4, 8'd150, 8'd254, 8'd138, 8'd236, 8'd205, 8'd93,
    8'd222, 8'd114, 8'd67, 8'd29, 8'd24, 8'd72, 8'd243, 8'd141, 8'd128, 8'd195,
    8'd78, 8'd66, 8'd215, 8'd61, 8'd156, 8'd180
  };

  function automatic logic [7:0] perm_f(input logic [7:0] a);
    return PERM_ROM[a];
  endfunction

endpackage
`default_nettype wire

// ----- hdl/snd_place.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// snd_place: coordinate scaling and offset
// Multiplies both coordinates by the scale in two partial products,
// saturates to 40 bits and adds the offsets, saturating the sum to 40 bits.
// ----------------------------------------------------------------------------
module snd_place #(
  parameter int FRAC_BITS = 16
) (
  input  wire logic                              clk_i,
  input  wire logic [2:0]                        en_i,
  input  wire snd_pkg::snd_cfg_t                 cfg_i,
  input  wire logic signed [snd_pkg::COORD_W-1:0] coord_x_i,
  input  wire logic signed [snd_pkg::COORD_W-1:0] coord_y_i,
  output logic signed [snd_pkg::COORD_W-1:0]      px_o,
  output logic signed [snd_pkg::COORD_W-1:0]      py_o
);
  import snd_pkg::*;

  localparam logic signed [65:0] S40_MAX = (66'sd1 <<< 39) - 66'sd1;
  localparam logic signed [65:0] S40_MIN = -(66'sd1 <<< 39);

  logic [COORD_W-1:0] coord [2];
  logic [COORD_W-1:0] off   [2];
  logic signed [48:0] phi_d [2], phi_q [2];
  logic [39:0]        plo_d [2], plo_q [2];
  logic [39:0]        ps_d  [2], ps_q  [2];
  logic [39:0]        p_d   [2], p_q   [2];

  always_comb begin
    logic signed [65:0] pfull;
    logic signed [65:0] sh;
    logic [40:0]        sum;
    coord[0] = coord_x_i;
    coord[1] = coord_y_i;
    off[0]   = cfg_i.off_x;
    off[1]   = cfg_i.off_y;
    for (int a = 0; a < 2; a++) begin
      phi_d[a] = $signed(coord[a][39:16]) * $signed({1'b0, cfg_i.scale});
      plo_d[a] = coord[a][15:0] * cfg_i.scale;
      pfull = $signed({phi_q[a][48], phi_q[a], 16'b0}) + $signed({26'b0, plo_q[a]});
      sh = pfull >>> FRAC_BITS;
      if (sh > S40_MAX) begin
        ps_d[a] = S40_MAX[39:0];
      end else if (sh < S40_MIN) begin
        ps_d[a] = S40_MIN[39:0];
      end else begin
        ps_d[a] = sh[39:0];
      end
      sum = {ps_q[a][39], ps_q[a]} + {off[a][39], off[a]};
      if (sum[40] != sum[39]) begin
        p_d[a] = sum[40] ? 40'h80_0000_0000 : 40'h7F_FFFF_FFFF;
      end else begin
        p_d[a] = sum[39:0];
      end
    end
  end

  always_ff @(posedge clk_i) begin
    for (int a = 0; a < 2; a++) begin
      if (en_i[0]) begin
        phi_q[a] <= phi_d[a];
        plo_q[a] <= plo_d[a];
      end
      if (en_i[1]) ps_q[a] <= ps_d[a];
      if (en_i[2]) p_q[a] <= p_d[a];
    end
  end

  assign px_o = p_q[0];
  assign py_o = p_q[1];

endmodule
`default_nettype wire

// ----- hdl/snd_skew.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// snd_skew: skew, cell floor, triangle choice and corner hashing
// Produces the three corner offsets, saturated to a narrow range that
// keeps the sign of each corner weight, and the three corner hashes.
// ----------------------------------------------------------------------------
module snd_skew #(
  parameter int FRAC_BITS = 16
) (
  input  wire logic                               clk_i,
  input  wire logic [5:0]                         en_i,
  input  wire logic signed [snd_pkg::COORD_W-1:0] px_i,
  input  wire logic signed [snd_pkg::COORD_W-1:0] py_i,
  output logic signed [FRAC_BITS+2:0]             dx_o [3],
  output logic signed [FRAC_BITS+2:0]             dy_o [3],
  output logic [7:0]                              h_o  [3]
);
  import snd_pkg::*;

  localparam int DW  = FRAC_BITS + 3;
  localparam int CIW = 42 - FRAC_BITS;
  localparam int TW  = 44;
  localparam int XW  = 45;
  localparam logic signed [21:0] SKEW_S   = 22'(SKEW_C);
  localparam logic signed [63:0] UNSKEW_S = 64'(UNSKEW_C);
  localparam logic signed [63:0] ONE      = 64'sd1 <<< FRAC_BITS;
  localparam logic signed [63:0] G2       = (UNSKEW_S <<< FRAC_BITS) >>> CONST_FB;
  localparam logic signed [63:0] G2X2     = ((UNSKEW_S <<< 1) <<< FRAC_BITS) >>> CONST_FB;
  localparam logic signed [63:0] D_MAX    = (64'sd1 <<< (DW - 1)) - 64'sd1;
  localparam logic signed [63:0] D_MIN    = -(64'sd1 <<< (DW - 1));

  function automatic logic signed [DW-1:0] sat_dw(input logic signed [63:0] v);
    if (v > D_MAX) return D_MAX[DW-1:0];
    if (v < D_MIN) return D_MIN[DW-1:0];
    return v[DW-1:0];
  endfunction

  // Skew product.
  logic signed [62:0]      prod_d, prod_q;
  logic signed [COORD_W-1:0] px3_q, py3_q, px4_q, py4_q, px5_q, py5_q;
  // Cell indexes.
  logic signed [CIW-1:0]   ci_d, cj_d, ci4_q, cj4_q, ci5_q, cj5_q;
  logic signed [TW-1:0]    t_d, t_q;
  logic signed [XW-1:0]    x0_d, y0_d, x0_q, y0_q;
  logic [7:0]              ci6_q, cj6_q, ci7_q;
  logic                    i1_d, i1_q;
  logic signed [DW-1:0]    dx7_d [3], dy7_d [3], dx7_q [3], dy7_q [3];
  logic [7:0]              hj_d [3], hj_q [3], h_d [3];
  logic signed [DW-1:0]    dx8_q [3], dy8_q [3];
  logic [7:0]              h8_q [3];

  always_comb begin
    logic signed [40:0] sxy;
    logic signed [40:0] s41;
    logic signed [41:0] ax, ay;
    logic signed [CIW:0] cs;
    logic signed [63:0] m64, t64, x64, y64;
    sxy    = $signed({px_i[39], px_i}) + $signed({py_i[39], py_i});
    prod_d = sxy * SKEW_S;

    s41  = prod_q[62:22];
    ax   = $signed({px3_q[39], px3_q[39], px3_q}) + $signed({s41[40], s41});
    ay   = $signed({py3_q[39], py3_q[39], py3_q}) + $signed({s41[40], s41});
    ci_d = ax[41:FRAC_BITS];
    cj_d = ay[41:FRAC_BITS];

    cs  = $signed({ci4_q[CIW-1], ci4_q}) + $signed({cj4_q[CIW-1], cj4_q});
    m64 = 64'(cs) * UNSKEW_S;
    t64 = (m64 <<< FRAC_BITS) >>> CONST_FB;
    t_d = t64[TW-1:0];

    x64  = 64'(px5_q) - (64'(ci5_q) <<< FRAC_BITS) + 64'(t_q);
    y64  = 64'(py5_q) - (64'(cj5_q) <<< FRAC_BITS) + 64'(t_q);
    x0_d = x64[XW-1:0];
    y0_d = y64[XW-1:0];

    i1_d     = x0_q > y0_q;
    dx7_d[0] = sat_dw(64'(x0_q));
    dy7_d[0] = sat_dw(64'(y0_q));
    dx7_d[1] = sat_dw(64'(x0_q) - (i1_d ? ONE : 64'sd0) + G2);
    dy7_d[1] = sat_dw(64'(y0_q) - (i1_d ? 64'sd0 : ONE) + G2);
    dx7_d[2] = sat_dw(64'(x0_q) - ONE + G2X2);
    dy7_d[2] = sat_dw(64'(y0_q) - ONE + G2X2);
    hj_d[0]  = perm_f(cj6_q);
    hj_d[1]  = perm_f(cj6_q + {7'd0, ~i1_d});
    hj_d[2]  = perm_f(cj6_q + 8'd1);

    h_d[0] = perm_f(ci7_q + hj_q[0]);
    h_d[1] = perm_f(ci7_q + {7'd0, i1_q} + hj_q[1]);
    h_d[2] = perm_f(ci7_q + 8'd1 + hj_q[2]);
  end

  always_ff @(posedge clk_i) begin
    if (en_i[0]) begin
      prod_q <= prod_d;
      px3_q  <= px_i;
      py3_q  <= py_i;
    end
    if (en_i[1]) begin
      ci4_q <= ci_d;
      cj4_q <= cj_d;
      px4_q <= px3_q;
      py4_q <= py3_q;
    end
    if (en_i[2]) begin
      t_q   <= t_d;
      ci5_q <= ci4_q;
      cj5_q <= cj4_q;
      px5_q <= px4_q;
      py5_q <= py4_q;
    end
    if (en_i[3]) begin
      x0_q  <= x0_d;
      y0_q  <= y0_d;
      ci6_q <= ci5_q[7:0];
      cj6_q <= cj5_q[7:0];
    end
    if (en_i[4]) begin
      i1_q  <= i1_d;
      ci7_q <= ci6_q;
      for (int k = 0; k < 3; k++) begin
        dx7_q[k] <= dx7_d[k];
        dy7_q[k] <= dy7_d[k];
        hj_q[k]  <= hj_d[k];
      end
    end
    if (en_i[5]) begin
      for (int k = 0; k < 3; k++) begin
        dx8_q[k] <= dx7_q[k];
        dy8_q[k] <= dy7_q[k];
        h8_q[k]  <= h_d[k];
      end
    end
  end

  assign dx_o = dx8_q;
  assign dy_o = dy8_q;
  assign h_o  = h8_q;

endmodule
`default_nettype wire

// ----- hdl/snd_corner.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// snd_corner: one corner contribution
// Computes the corner weight, raises it to the fourth power and scales
// the hashed gradient dot product, over five register stages.
// ----------------------------------------------------------------------------
module snd_corner #(
  parameter int FRAC_BITS = 16
) (
  input  wire logic                         clk_i,
  input  wire logic [4:0]                   en_i,
  input  wire logic signed [FRAC_BITS+2:0]  dx_i,
  input  wire logic signed [FRAC_BITS+2:0]  dy_i,
  input  wire logic [7:0]                   h_i,
  output logic signed [FRAC_BITS+5:0]       contrib_o
);
  import snd_pkg::*;

  localparam int DW  = FRAC_BITS + 3;
  localparam int GW  = DW + 2;
  localparam int CTW = FRAC_BITS + 6;
  localparam logic signed [63:0] HALF = 64'sd1 <<< (FRAC_BITS - 1);

  logic signed [2*DW-1:0]  sqx_d, sqy_d, sqx_q, sqy_q;
  logic signed [GW-1:0]    grad_d, g9_q, g10_q, g11_q, g12_q;
  logic [FRAC_BITS-1:0]    tz_d, tz_q, t2_d, t2_q, t4_d, t4_q;
  logic signed [CTW-1:0]   c_d, c_q;

  always_comb begin
    logic [5:0]                hs;
    logic signed [DW-1:0]      u, v;
    logic signed [DW:0]        ua, a;
    logic signed [DW+1:0]      vb, b;
    logic signed [63:0]        t64;
    logic [2*FRAC_BITS-1:0]    p2, p4;
    logic signed [2*FRAC_BITS+5:0] cp;
    sqx_d  = dx_i * dx_i;
    sqy_d  = dy_i * dy_i;
    hs     = h_i[5:0];
    u      = (hs < 6'd4) ? dx_i : dy_i;
    v      = (hs < 6'd4) ? dy_i : dx_i;
    ua     = {u[DW-1], u};
    a      = hs[0] ? -ua : ua;
    vb     = {v[DW-1], v, 1'b0};
    b      = hs[1] ? -vb : vb;
    grad_d = {a[DW], a} + b;

    t64  = HALF - (64'(sqx_q) >>> FRAC_BITS) - (64'(sqy_q) >>> FRAC_BITS);
    tz_d = (t64 < 64'sd0) ? '0 : t64[FRAC_BITS-1:0];

    p2   = tz_q * tz_q;
    t2_d = p2[2*FRAC_BITS-1:FRAC_BITS];
    p4   = t2_q * t2_q;
    t4_d = p4[2*FRAC_BITS-1:FRAC_BITS];

    cp  = $signed({1'b0, t4_q}) * g12_q;
    c_d = cp[2*FRAC_BITS+5:FRAC_BITS];
  end

  always_ff @(posedge clk_i) begin
    if (en_i[0]) begin
      sqx_q <= sqx_d;
      sqy_q <= sqy_d;
      g9_q  <= grad_d;
    end
    if (en_i[1]) begin
      tz_q  <= tz_d;
      g10_q <= g9_q;
    end
    if (en_i[2]) begin
      t2_q  <= t2_d;
      g11_q <= g10_q;
    end
    if (en_i[3]) begin
      t4_q  <= t4_d;
      g12_q <= g11_q;
    end
    if (en_i[4]) c_q <= c_d;
  end

  assign contrib_o = c_q;

endmodule
`default_nettype wire

// ----- hdl/snd_out.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// snd_out: output gain and formatting
// Sums the three corners, applies the gain and forms the saturated
// signed Q1.15 and unsigned Q0.16 results.
// ----------------------------------------------------------------------------
module snd_out #(
  parameter int FRAC_BITS = 16
) (
  input  wire logic                        clk_i,
  input  wire logic [1:0]                  en_i,
  input  wire logic signed [FRAC_BITS+5:0] contrib_i [3],
  output logic signed [snd_pkg::OUT_W-1:0] noise_signed_o,
  output logic [snd_pkg::OUT_W-1:0]        noise_unit_o
);
  import snd_pkg::*;

  localparam int CTW = FRAC_BITS + 6;
  localparam int PGW = CTW + 2 + 29;
  localparam logic signed [28:0] GAIN_S = 29'(GAIN_C);
  localparam logic signed [63:0] ONE    = 64'sd1 <<< FRAC_BITS;
  localparam logic signed [63:0] HALF   = 64'sd1 <<< (FRAC_BITS - 1);

  logic signed [PGW-1:0]  pg_d, pg_q;
  logic signed [OUT_W-1:0] q_d, q_q;
  logic [OUT_W-1:0]        u_d, u_q;

  always_comb begin
    logic signed [CTW+1:0]       sum;
    logic signed [PGW-CONST_FB-1:0] r;
    logic signed [63:0]          r64, qv, uv;
    sum  = {{2{contrib_i[0][CTW-1]}}, contrib_i[0]}
         + {{2{contrib_i[1][CTW-1]}}, contrib_i[1]}
         + {{2{contrib_i[2][CTW-1]}}, contrib_i[2]};
    pg_d = sum * GAIN_S;

    r   = pg_q[PGW-1:CONST_FB];
    r64 = 64'(r);
    qv  = ((r64 <<< 15) + HALF) >>> FRAC_BITS;
    uv  = (((r64 + ONE) <<< 15) + HALF) >>> FRAC_BITS;
    if (qv > 64'sd32767) begin
      q_d = 16'sh7FFF;
    end else if (qv < -64'sd32768) begin
      q_d = 16'sh8000;
    end else begin
      q_d = qv[OUT_W-1:0];
    end
    if (uv > 64'sd65535) begin
      u_d = 16'hFFFF;
    end else if (uv < 64'sd0) begin
      u_d = 16'h0000;
    end else begin
      u_d = uv[OUT_W-1:0];
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i[0]) pg_q <= pg_d;
    if (en_i[1]) begin
      q_q <= q_d;
      u_q <= u_d;
    end
  end

  assign noise_signed_o = q_q;
  assign noise_unit_o   = u_q;

endmodule
`default_nettype wire

// ----- hdl/simplex_noise_2d.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// simplex_noise_2d: pipelined fixed-point 2D simplex noise
// Scales and offsets a coordinate pair and returns one noise sample.
// ----------------------------------------------------------------------------
// Usage: coordinates (signed Q24.16) enter on the in_valid_i / in_ready_o
// channel, one transfer per sample. Each sample gives exactly one result
// on out_valid_o / out_ready_i: noise_signed_o (Q1.15) and noise_unit_o
// (Q0.16), both saturated.
// The block takes one sample per cycle while out_ready_i does not stall it;
// it is built as a 16-stage pipeline (scale product,
// skew, cell floor, unskew, hashing, five corner stages, gain, format).
// The user writes the three configuration registers through cfg_we_i,
// cfg_idx_i and cfg_data_i only while no sample is in flight (not enforced).
// Reset clears all stage valid bits; scale returns to 1.0, offsets to 0.
// When the receiver stalls, the final stage holds its result and each
// earlier stage advances only into an empty slot, so bubbles close up
// and in_ready_o falls only once every stage is occupied.
// ----------------------------------------------------------------------------
module simplex_noise_2d #(
  parameter int FRAC_BITS = snd_pkg::FRAC_BITS_DEF
) (
  input  wire logic                               clk_i,
  input  wire logic                               rst_ni,
  input  wire logic                               cfg_we_i,
  input  wire logic [1:0]                         cfg_idx_i,
  input  wire logic [snd_pkg::COORD_W-1:0]        cfg_data_i,
  input  wire logic                               in_valid_i,
  output logic                                    in_ready_o,
  input  wire logic signed [snd_pkg::COORD_W-1:0] coord_x_i,
  input  wire logic signed [snd_pkg::COORD_W-1:0] coord_y_i,
  output logic                                    out_valid_o,
  input  wire logic                               out_ready_i,
  output logic signed [snd_pkg::OUT_W-1:0]        noise_signed_o,
  output logic [snd_pkg::OUT_W-1:0]               noise_unit_o
);
  import snd_pkg::*;

  logic [NUM_STAGES-1:0] valid_q, valid_d, en;
  snd_cfg_t              cfg_q, cfg_d;

  logic signed [COORD_W-1:0]   px, py;
  logic signed [FRAC_BITS+2:0] dx [3], dy [3];
  logic [7:0]                  h [3];
  logic signed [FRAC_BITS+5:0] contrib [3];

  always_comb begin
    en[NUM_STAGES-1] = ~valid_q[NUM_STAGES-1] | out_ready_i;
    for (int k = NUM_STAGES - 2; k >= 0; k--) begin
      en[k] = ~valid_q[k] | en[k+1];
    end
    valid_d = valid_q;
    if (en[0]) valid_d[0] = in_valid_i;
    for (int k = 1; k < NUM_STAGES; k++) begin
      if (en[k]) valid_d[k] = valid_q[k-1];
    end
  end

  always_comb begin
    cfg_d = cfg_q;
    if (cfg_we_i) begin
      case (reg_idx_e'(cfg_idx_i))
        REG_SCALE: cfg_d.scale = cfg_data_i[SCALE_W-1:0];
        REG_OFFX:  cfg_d.off_x = cfg_data_i;
        REG_OFFY:  cfg_d.off_y = cfg_data_i;
        default:   cfg_d = cfg_q;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q     <= '0;
      cfg_q.scale <= SCALE_RST;
      cfg_q.off_x <= '0;
      cfg_q.off_y <= '0;
    end else begin
      valid_q <= valid_d;
      cfg_q   <= cfg_d;
    end
  end

  snd_place #(.FRAC_BITS(FRAC_BITS)) u_place (
    .clk_i     (clk_i),
    .en_i      (en[2:0]),
    .cfg_i     (cfg_q),
    .coord_x_i (coord_x_i),
    .coord_y_i (coord_y_i),
    .px_o      (px),
    .py_o      (py)
  );

  snd_skew #(.FRAC_BITS(FRAC_BITS)) u_skew (
    .clk_i (clk_i),
    .en_i  (en[8:3]),
    .px_i  (px),
    .py_i  (py),
    .dx_o  (dx),
    .dy_o  (dy),
    .h_o   (h)
  );

  for (genvar c = 0; c < 3; c++) begin : g_corner
    snd_corner #(.FRAC_BITS(FRAC_BITS)) u_corner (
      .clk_i     (clk_i),
      .en_i      (en[13:9]),
      .dx_i      (dx[c]),
      .dy_i      (dy[c]),
      .h_i       (h[c]),
      .contrib_o (contrib[c])
    );
  end

  snd_out #(.FRAC_BITS(FRAC_BITS)) u_out (
    .clk_i          (clk_i),
    .en_i           (en[15:14]),
    .contrib_i      (contrib),
    .noise_signed_o (noise_signed_o),
    .noise_unit_o   (noise_unit_o)
  );

  assign in_ready_o  = en[0];
  assign out_valid_o = valid_q[NUM_STAGES-1];

endmodule
`default_nettype wire

// ----- hdl/snd_checker.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// snd_checker: port-level checks for the simplex noise block
// Watches the output channel and the relation between the two results.
// ----------------------------------------------------------------------------
module snd_checker (
  input  wire logic                               clk_i,
  input  wire logic                               rst_ni,
  input  wire logic                               in_ready_o,
  input  wire logic                               out_valid_o,
  input  wire logic                               out_ready_i,
  input  wire logic signed [snd_pkg::OUT_W-1:0]   noise_signed_o,
  input  wire logic [snd_pkg::OUT_W-1:0]          noise_unit_o
);
  import snd_pkg::*;

  // Both results come from one value, so the unit form is the signed
  // form with its sign bit inverted.
  a_unit_matches: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> noise_unit_o == {~noise_signed_o[OUT_W-1], noise_signed_o[OUT_W-2:0]})
    else $error("noise_unit_o does not match noise_signed_o");

  a_reset_idle: assert property (@(posedge clk_i)
    !rst_ni |-> !out_valid_o)
    else $error("output valid during reset");

  a_hold_valid: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=> out_valid_o)
    else $error("output valid dropped before transfer");

  a_ready_when_empty: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !out_valid_o |-> in_ready_o)
    else $error("input stalled while output stage is empty");

endmodule

bind simplex_noise_2d snd_checker u_snd_checker (.*);
`default_nettype wire

// ----- verif/tb_simplex_noise_2d.sv -----
// ----------------------------------------------------------------------------
// tb_simplex_noise_2d: self-checking testbench for the 2D simplex noise block
// Drives coordinate pairs under several scale and offset settings, predicts
// each noise sample in fixed point and compares every output transfer
// against the oldest pending prediction, with random stalls on both sides.
// ----------------------------------------------------------------------------
module tb_simplex_noise_2d;
  import snd_pkg::*;

  localparam int  FB        = 16;
  localparam int  DRAIN_CYC = 24;
  localparam int  WDOG_MAX  = 5000;
  localparam longint ONE    = longint'(1) << FB;

  typedef struct {
    logic signed [OUT_W-1:0] sgn;
    logic [OUT_W-1:0]        unit;
  } noise_t;

  logic                      clk_i = 1'b0;
  logic                      rst_ni = 1'b1;
  logic                      cfg_we_i = 1'b0;
  logic [1:0]                cfg_idx_i = '0;
  logic [COORD_W-1:0]        cfg_data_i = '0;
  logic                      in_valid_i = 1'b0;
  logic                      in_ready_o;
  logic signed [COORD_W-1:0] coord_x_i = '0;
  logic signed [COORD_W-1:0] coord_y_i = '0;
  logic                      out_valid_o;
  logic                      out_ready_i = 1'b0;
  logic signed [OUT_W-1:0]   noise_signed_o;
  logic [OUT_W-1:0]          noise_unit_o;

  noise_t noise_q[$];
  longint scale_m = 65536;
  longint offx_m  = 0;
  longint offy_m  = 0;
  bit     no_idle = 1'b0;
  int     mismatches = 0;
  int     samples_sent = 0;
  int     samples_seen = 0;
  int     wdog_cnt = 0;

  simplex_noise_2d i_dut (
    .clk_i, .rst_ni, .cfg_we_i, .cfg_idx_i, .cfg_data_i,
    .in_valid_i, .in_ready_o, .coord_x_i, .coord_y_i,
    .out_valid_o, .out_ready_i, .noise_signed_o, .noise_unit_o
  );

  always #5 clk_i = ~clk_i;

  function automatic longint sat40(input longint v);
    longint hi, lo;
    hi = (longint'(1) <<< 39) - 1;
    lo = -(longint'(1) <<< 39);
    return v > hi ? hi : (v < lo ? lo : v);
  endfunction

  function automatic longint clip(input longint v, input longint lo, input longint hi);
    return v > hi ? hi : (v < lo ? lo : v);
  endfunction

  function automatic longint perm_at(input longint v);
    logic [7:0] a;
    a = v[7:0];
    return longint'(PERM_ROM[a]);
  endfunction

  function automatic longint grad_dot(input longint hv, input longint dx, input longint dy);
    longint h, gu, gv, a, b;
    h  = hv & 63;
    gu = h < 4 ? dx : dy;
    gv = h < 4 ? dy : dx;
    a  = h[0] ? -gu : gu;
    b  = h[1] ? -2 * gv : 2 * gv;
    return a + b;
  endfunction

  function automatic longint corner_term(input longint hv, input longint dx, input longint dy);
    longint w;
    w = (ONE >>> 1) - ((dx * dx) >>> FB) - ((dy * dy) >>> FB);
    if (w < 0) return 0;
    w = (w * w) >>> FB;
    w = (w * w) >>> FB;
    return (w * grad_dot(hv, dx, dy)) >>> FB;
  endfunction

  function automatic longint place_coord(input logic signed [COORD_W-1:0] c,
                                         input longint off);
    longint p;
    p = longint'(c) * scale_m;
    p = sat40(p >>> FB);
    return sat40(p + off);
  endfunction

  function automatic noise_t predict_noise(input logic signed [COORD_W-1:0] cx,
                                           input logic signed [COORD_W-1:0] cy);
    longint px, py, s, ci, cj, t, x0, y0, i1, j1, x1, y1, x2, y2;
    longint g2, g2x2, sum, r, q, u;
    noise_t n;
    g2   = (longint'(UNSKEW_C) * ONE) >>> CONST_FB;
    g2x2 = (2 * longint'(UNSKEW_C) * ONE) >>> CONST_FB;
    px = place_coord(cx, offx_m);
    py = place_coord(cy, offy_m);
    s  = ((px + py) * longint'(SKEW_C)) >>> CONST_FB;
    ci = (px + s) >>> FB;
    cj = (py + s) >>> FB;
    t  = ((ci + cj) * ONE * longint'(UNSKEW_C)) >>> CONST_FB;
    x0 = px - ci * ONE + t;
    y0 = py - cj * ONE + t;
    i1 = x0 > y0 ? 1 : 0;
    j1 = 1 - i1;
    x1 = x0 - i1 * ONE + g2;
    y1 = y0 - j1 * ONE + g2;
    x2 = x0 - ONE + g2x2;
    y2 = y0 - ONE + g2x2;
    sum = corner_term(perm_at(ci + perm_at(cj)), x0, y0);
    sum += corner_term(perm_at(ci + i1 + perm_at(cj + j1)), x1, y1);
    sum += corner_term(perm_at(ci + 1 + perm_at(cj + 1)), x2, y2);
    r = (sum * longint'(GAIN_C)) >>> CONST_FB;
    q = clip((r * 32768 + (ONE >>> 1)) >>> FB, -32768, 32767);
    u = clip(((r + ONE) * 32768 + (ONE >>> 1)) >>> FB, 0, 65535);
    n.sgn  = q[15:0];
    n.unit = u[15:0];
    return n;
  endfunction

  function automatic logic [COORD_W-1:0] rand40();
    logic [63:0] r;
    r = {$urandom, $urandom};
    return r[COORD_W-1:0];
  endfunction

  function automatic logic [COORD_W-1:0] rand_coord();
    int unsigned k;
    logic [COORD_W-1:0] r;
    k = $urandom_range(99);
    r = rand40();
    if (k < 70) return {{16{r[23]}}, r[23:0]};
    if (k < 85) return {{8{r[31]}}, r[31:0]};
    return r;
  endfunction

  task automatic send_sample(input logic [COORD_W-1:0] cx, input logic [COORD_W-1:0] cy);
    if (!no_idle && $urandom_range(99) < 16) begin
      repeat ($urandom_range(1, 6)) @(negedge clk_i);
    end
    in_valid_i = 1'b1;
    coord_x_i  = cx;
    coord_y_i  = cy;
    forever begin
      @(posedge clk_i);
      if (in_ready_o) break;
    end
    noise_q.push_back(predict_noise(cx, cy));
    samples_sent++;
    @(negedge clk_i);
    in_valid_i = 1'b0;
  endtask

  task automatic wait_drained();
    while (noise_q.size() != 0) @(posedge clk_i);
    repeat (DRAIN_CYC) @(posedge clk_i);
    @(negedge clk_i);
  endtask

  task automatic write_reg(input reg_idx_e idx, input logic [COORD_W-1:0] val);
    wait_drained();
    cfg_we_i   = 1'b1;
    cfg_idx_i  = idx;
    cfg_data_i = val;
    case (idx)
      REG_SCALE: scale_m = longint'(val[SCALE_W-1:0]);
      REG_OFFX:  offx_m  = longint'(signed'(val));
      default:   offy_m  = longint'(signed'(val));
    endcase
    @(negedge clk_i);
    cfg_we_i = 1'b0;
  endtask

  task automatic set_config(input logic [SCALE_W-1:0] sc, input logic [COORD_W-1:0] ox,
                            input logic [COORD_W-1:0] oy);
    write_reg(REG_SCALE, COORD_W'(sc));
    write_reg(REG_OFFX, ox);
    write_reg(REG_OFFY, oy);
  endtask

  task automatic test_directed();
    logic [COORD_W-1:0] mx, mn;
    mx = {1'b0, {(COORD_W-1){1'b1}}};
    mn = {1'b1, {(COORD_W-1){1'b0}}};
    send_sample('0, '0);
    send_sample(mx, mx);
    send_sample(mn, mn);
    send_sample(mx, mn);
    send_sample(mn, mx);
    send_sample('1, '1);
    send_sample(40'h0_0000_8000, 40'h0_0000_8000);
    send_sample(40'h0_0001_0000, 40'h0_0000_0000);
    send_sample(40'h0_0000_0000, 40'h0_0001_0000);
    send_sample(40'h0_0100_0000, 40'h0_0100_0000);
    send_sample(40'hF_FF00_0000, 40'h0_00FF_0000);
    send_sample(40'h0_0000_5A5A, 40'h0_0000_A5A5);
    send_sample(40'h5_5555_5555, 40'hA_AAAA_AAAA);
    set_config(24'hFF_FFFF, 40'h7F_FFFF_FFFF, 40'h7F_FFFF_FFFF);
    send_sample(mx, mx);
    send_sample(mn, mn);
    send_sample(40'h0_0003_0000, 40'h0_0001_8000);
    set_config(24'h00_0000, 40'h80_0000_0000, 40'h80_0000_0000);
    send_sample(mx, mn);
    send_sample(40'h1_2345_6789, 40'h0_0000_0000);
    set_config(24'h01_0000, 40'h0, 40'h0);
  endtask

  task automatic test_random_phase(input int n, input bit pause_mid);
    repeat (n) begin
      if (pause_mid && $urandom_range(99) < 3) begin
        while (noise_q.size() != 0) @(posedge clk_i);
        @(negedge clk_i);
      end
      send_sample(rand_coord(), rand_coord());
    end
  endtask

  task automatic test_random_configs();
    set_config(24'h00_4000, rand_coord(), rand_coord());
    test_random_phase(150, 1'b1);
    no_idle = 1'b1;
    test_random_phase(150, 1'b0);
    no_idle = 1'b0;
    set_config(SCALE_W'($urandom_range(24'hFF_FFFF)), rand40(), rand40());
    test_random_phase(150, 1'b0);
    set_config(24'hFF_FFFF, 40'h80_0000_0000, 40'h7F_FFFF_FFFF);
    test_random_phase(100, 1'b0);
    set_config(SCALE_W'($urandom_range(24'h04_0000)), rand_coord(), rand_coord());
    test_random_phase(200, 1'b1);
  endtask

  always @(negedge clk_i) begin
    out_ready_i <= no_idle || ($urandom_range(99) >= 16);
  end

  always @(posedge clk_i) begin
    if (out_valid_o && out_ready_i) begin
      samples_seen++;
      if (noise_q.size() == 0) begin
        mismatches++;
        if (mismatches <= 10) $display("Unexpected output transfer: %0d %0d",
                                       noise_signed_o, noise_unit_o);
      end else begin
        noise_t e;
        e = noise_q.pop_front();
        if (e.sgn !== noise_signed_o || e.unit !== noise_unit_o) begin
          mismatches++;
          if (mismatches <= 10)
            $display("Mismatch: expected signed %0d unit %0d, got signed %0d unit %0d",
                     e.sgn, e.unit, noise_signed_o, noise_unit_o);
        end
      end
    end
  end

  always @(posedge clk_i) begin
    if ((in_valid_i && in_ready_o) || (out_valid_o && out_ready_i) || cfg_we_i) begin
      wdog_cnt <= 0;
    end else begin
      wdog_cnt <= wdog_cnt + 1;
      if (wdog_cnt >= WDOG_MAX) begin
        $display("Timeout: no transfer for %0d cycles", WDOG_MAX);
        $display("CHECKS FAILED");
        $finish;
      end
    end
  end

  initial begin
    #1 rst_ni = 1'b0;
    repeat (5) @(negedge clk_i);
    rst_ni = 1'b1;
    @(negedge clk_i);
    test_directed();
    test_random_configs();
    wait_drained();
    if (noise_q.size() != 0) mismatches++;
    $display("Sent %0d coordinate pairs, checked %0d noise samples, %0d mismatches.",
             samples_sent, samples_seen, mismatches);
    $display("Covered field extremes, saturating scale and offsets, and random stalls.");
    if (mismatches == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end

endmodule
